// ===== src/lrup_pkg.sv =====
// shared types and constants for the led rgb udp packetizer
// used by lrup_framer, lrup_queue, lrup_serializer and the top level
`default_nettype none

package lrup_pkg;

  // frame size limits
  localparam int unsigned SINGLE_PACKET_MAX = 490;
  localparam int unsigned CHUNK_LEDS        = 489;

  // header bytes
  localparam logic [7:0] HDR_ID_SINGLE = 8'd2;
  localparam logic [7:0] HDR_ID_CHUNK  = 8'd4;
  localparam logic [7:0] HDR_MARK      = 8'hff;

  // kind of header that opens a record
  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_SINGLE,
    HDR_CHUNK
  } hdr_kind_t;

  // input word: one led
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_led;
  } led_word_t;

  // output word: one payload byte
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_end;
    logic       run_last;
  } byte_word_t;

  // framed led waiting for serialization
  typedef struct packed {
    hdr_kind_t   kind;
    logic [15:0] index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        pkt_end;
  } led_rec_t;

endpackage

`default_nettype wire

// ===== src/led_rgb_udp_packetizer.sv =====
// Real-time LED datagram framer. Each input word carries one LED colour; the block
// emits the payload bytes one per cycle while out_stall is low and LEDs are queued:
// red, green, blue per LED, preceded by 2, 255 when an LED opens a single-packet
// frame (led_count up to 490) or by 4, 255, index high, index low when it opens a
// chunk of up to 489 LEDs. An LED inside a packet gives three bytes, an LED that
// opens a packet five or seven. A two-entry queue sits between the framer and the
// byte serializer, so input words are taken while earlier LEDs are still being sent;
// in_stall rises when that queue is full. led_count is written through cfg_write /
// cfg_data; the user must write it only while the block is idle, the block does not enforce it.
// depends on lrup_pkg, lrup_framer, lrup_queue, lrup_serializer
`default_nettype none

module led_rgb_udp_packetizer (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_write,
  input  wire           [15:0] cfg_data,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  lrup_pkg::led_word_t  in_word,
  output logic                 out_valid,
  input  wire                  out_stall,
  output lrup_pkg::byte_word_t out_word
);

  lrup_pkg::led_rec_t rec;
  lrup_pkg::led_rec_t head_rec;
  logic accept;
  logic full;
  logic head_valid;
  logic pop;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // framing state
  lrup_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_word   (in_word),
    .rec       (rec)
  );

  // record buffer
  lrup_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_rec   (rec),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // byte output
  lrup_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

// ===== src/lrup_framer.sv =====
// framing decisions: tracks frame and packet position, tags each led with its header
// depends on lrup_pkg
`default_nettype none

module lrup_framer (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_write,
  input  wire          [15:0] cfg_data,
  input  wire                 accept,
  input  lrup_pkg::led_word_t in_word,
  output lrup_pkg::led_rec_t  rec
);

  logic [15:0] led_count;
  logic [8:0]  leds_in_chunk;
  logic [15:0] frame_led_index;
  logic [8:0]  leds_in_chunk_next;
  logic [15:0] frame_led_index_next;

  logic chunked;
  logic frame_end;
  logic pkt_end;

  // mode and packet / frame boundaries for the incoming led
  always_comb begin
    chunked   = ({16'd0, led_count} > 32'(lrup_pkg::SINGLE_PACKET_MAX));
    frame_end = in_word.last_led ||
                (({1'b0, frame_led_index} + 17'd1) >= {1'b0, led_count});
    pkt_end   = frame_end ||
                (chunked && (({1'b0, leds_in_chunk} + 10'd1) >=
                             10'(lrup_pkg::CHUNK_LEDS)));
  end

  // record for the serializer
  always_comb begin
    rec.index   = frame_led_index;
    rec.red     = in_word.red;
    rec.green   = in_word.green;
    rec.blue    = in_word.blue;
    rec.pkt_end = pkt_end;
    if (leds_in_chunk == 9'd0) begin
      rec.kind = chunked ? lrup_pkg::HDR_CHUNK : lrup_pkg::HDR_SINGLE;
    end else begin
      rec.kind = lrup_pkg::HDR_NONE;
    end
  end

  // position update
  always_comb begin
    leds_in_chunk_next   = leds_in_chunk;
    frame_led_index_next = frame_led_index;
    if (frame_end) begin
      leds_in_chunk_next   = 9'd0;
      frame_led_index_next = 16'd0;
    end else begin
      frame_led_index_next = frame_led_index + 16'd1;
      if (pkt_end) begin
        leds_in_chunk_next = 9'd0;
      end else if (leds_in_chunk != 9'h1ff) begin
        leds_in_chunk_next = leds_in_chunk + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count       <= 16'd1;
      leds_in_chunk   <= 9'd0;
      frame_led_index <= 16'd0;
    end else begin
      if (cfg_write) begin
        led_count <= cfg_data;
      end
      if (accept) begin
        leds_in_chunk   <= leds_in_chunk_next;
        frame_led_index <= frame_led_index_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/lrup_queue.sv =====
// two-entry queue of framed leds between framer and serializer
// depends on lrup_pkg
`default_nettype none

module lrup_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  lrup_pkg::led_rec_t  push_rec,
  input  wire                 pop,
  output logic                full,
  output logic                head_valid,
  output lrup_pkg::led_rec_t  head_rec
);

  lrup_pkg::led_rec_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_rec   = entry[rd_ptr];

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/lrup_serializer.sv =====
// byte serializer: walks the head record byte by byte into the output register
// depends on lrup_pkg
`default_nettype none

module lrup_serializer (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 head_valid,
  input  lrup_pkg::led_rec_t  head_rec,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output lrup_pkg::byte_word_t out_word
);

  logic [2:0] pos;
  logic [2:0] last_pos;
  logic       advance;
  lrup_pkg::byte_word_t word_next;

  // byte count of the head record minus one
  always_comb begin
    unique case (head_rec.kind)
      lrup_pkg::HDR_SINGLE: last_pos = 3'd4;
      lrup_pkg::HDR_CHUNK:  last_pos = 3'd6;
      default:              last_pos = 3'd2;
    endcase
  end

  // byte selection
  always_comb begin
    logic [2:0] body_pos;
    body_pos = 3'd0;
    word_next.payload_byte = 8'd0;
    word_next.packet_end   = 1'b0;
    word_next.run_last     = 1'b0;
    unique case (head_rec.kind)
      lrup_pkg::HDR_SINGLE: body_pos = pos - 3'd2;
      lrup_pkg::HDR_CHUNK:  body_pos = pos - 3'd4;
      default:              body_pos = pos;
    endcase
    if (head_rec.kind != lrup_pkg::HDR_NONE && pos == 3'd0) begin
      word_next.payload_byte = (head_rec.kind == lrup_pkg::HDR_CHUNK) ?
                               lrup_pkg::HDR_ID_CHUNK : lrup_pkg::HDR_ID_SINGLE;
    end else if (head_rec.kind != lrup_pkg::HDR_NONE && pos == 3'd1) begin
      word_next.payload_byte = lrup_pkg::HDR_MARK;
    end else if (head_rec.kind == lrup_pkg::HDR_CHUNK && pos == 3'd2) begin
      word_next.payload_byte = head_rec.index[15:8];
    end else if (head_rec.kind == lrup_pkg::HDR_CHUNK && pos == 3'd3) begin
      word_next.payload_byte = head_rec.index[7:0];
    end else begin
      unique case (body_pos)
        3'd0:    word_next.payload_byte = head_rec.red;
        3'd1:    word_next.payload_byte = head_rec.green;
        default: begin
          word_next.payload_byte = head_rec.blue;
          word_next.packet_end   = head_rec.pkt_end;
          word_next.run_last     = 1'b1;
        end
      endcase
    end
  end

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && head_valid && (pos == last_pos);

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 3'd0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        pos <= (pos == last_pos) ? 3'd0 : pos + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for led_rgb_udp_packetizer: led words in, payload bytes out
// expected bytes come from a cycle-free framing predictor and are compared in order
// depends on lrup_pkg and the led_rgb_udp_packetizer rtl
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_LEDS = 215;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  lrup_pkg::led_word_t  in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  lrup_pkg::byte_word_t out_word;

  // predictor state
  int unsigned led_count_q = 1;
  int unsigned chunk_fill = 0;
  int unsigned frame_pos = 0;
  lrup_pkg::byte_word_t pending_bytes[$];
  int unsigned mismatches = 0;

  // sender and receiver pacing
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_tick = 0;
  int unsigned idle_cycles = 0;

  led_rgb_udp_packetizer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_byte(logic [7:0] b, logic pend, logic rlast);
    lrup_pkg::byte_word_t w;
    w = '{payload_byte: b, packet_end: pend, run_last: rlast};
    pending_bytes = {pending_bytes, w};
  endfunction

  // frame one led: header when it opens a packet, then its three colour bytes
  function automatic void frame_led(lrup_pkg::led_word_t w);
    bit chunked;
    bit frame_done;
    bit pkt_done;
    chunked = led_count_q > lrup_pkg::SINGLE_PACKET_MAX;
    if (chunk_fill == 0) begin
      if (chunked) begin
        push_byte(lrup_pkg::HDR_ID_CHUNK, 1'b0, 1'b0);
        push_byte(lrup_pkg::HDR_MARK, 1'b0, 1'b0);
        push_byte(frame_pos[15:8], 1'b0, 1'b0);
        push_byte(frame_pos[7:0], 1'b0, 1'b0);
      end else begin
        push_byte(lrup_pkg::HDR_ID_SINGLE, 1'b0, 1'b0);
        push_byte(lrup_pkg::HDR_MARK, 1'b0, 1'b0);
      end
    end
    frame_done = w.last_led || (frame_pos + 1 >= led_count_q);
    pkt_done = frame_done || (chunked && chunk_fill + 1 >= lrup_pkg::CHUNK_LEDS);
    push_byte(w.red, 1'b0, 1'b0);
    push_byte(w.green, 1'b0, 1'b0);
    push_byte(w.blue, pkt_done, 1'b1);
    if (frame_done) begin
      frame_pos = 0;
      chunk_fill = 0;
    end else begin
      frame_pos = (frame_pos + 1) & 32'hffff;
      if (pkt_done) chunk_fill = 0;
      else if (chunk_fill < 32'hffff) chunk_fill = chunk_fill + 1;
    end
  endfunction

  function automatic lrup_pkg::led_word_t rand_led(bit last);
    lrup_pkg::led_word_t w;
    w.red = 8'($urandom);
    w.green = 8'($urandom);
    w.blue = 8'($urandom);
    w.last_led = last;
    return w;
  endfunction

  // offer one led word, in bursts with random gaps between them
  task automatic send_led(input lrup_pkg::led_word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_led(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_led_count(input logic [15:0] v);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    led_count_q = 32'(v);
  endtask

  // reset count of one: every led is a frame of its own
  task automatic test_reset_count();
    send_led('{red: 8'h00, green: 8'h00, blue: 8'h00, last_led: 1'b0});
    send_led('{red: 8'hff, green: 8'hff, blue: 8'hff, last_led: 1'b1});
    send_led('{red: 8'haa, green: 8'h55, blue: 8'hff, last_led: 1'b0});
  endtask

  // single-packet frames ended by count and by last_led
  task automatic test_single_frames();
    set_led_count(16'd4);
    send_led('{red: 8'h55, green: 8'haa, blue: 8'h00, last_led: 1'b0});
    send_led('{red: 8'hff, green: 8'h00, blue: 8'hff, last_led: 1'b0});
    send_led('{red: 8'h01, green: 8'h80, blue: 8'h7f, last_led: 1'b0});
    send_led('{red: 8'hfe, green: 8'h7f, blue: 8'h80, last_led: 1'b0});
    send_led('{red: 8'h12, green: 8'h34, blue: 8'h56, last_led: 1'b1});
    set_led_count(16'd490);
    send_led('{red: 8'h00, green: 8'hff, blue: 8'h00, last_led: 1'b1});
  endtask

  // zero count: each led closes a one-led frame
  task automatic test_zero_count();
    set_led_count(16'd0);
    send_led('{red: 8'hff, green: 8'h00, blue: 8'haa, last_led: 1'b0});
    send_led('{red: 8'h00, green: 8'hff, blue: 8'h55, last_led: 1'b0});
  endtask

  // chunk headers at the smallest and largest chunked counts
  task automatic test_chunk_headers();
    set_led_count(16'd491);
    send_led('{red: 8'h11, green: 8'h22, blue: 8'h33, last_led: 1'b0});
    send_led('{red: 8'hff, green: 8'hff, blue: 8'hff, last_led: 1'b1});
    set_led_count(16'hffff);
    send_led('{red: 8'h00, green: 8'h00, blue: 8'h00, last_led: 1'b0});
    send_led('{red: 8'haa, green: 8'haa, blue: 8'haa, last_led: 1'b0});
    send_led('{red: 8'h55, green: 8'h55, blue: 8'h55, last_led: 1'b1});
  endtask

  // count written mid-frame keeps the frame position
  task automatic test_count_change();
    set_led_count(16'd400);
    send_led(rand_led(1'b0));
    send_led(rand_led(1'b0));
    send_led(rand_led(1'b0));
    set_led_count(16'd2);
    send_led(rand_led(1'b0));
    set_led_count(16'd400);
    send_led(rand_led(1'b0));
    send_led(rand_led(1'b0));
    set_led_count(16'd1000);
    send_led(rand_led(1'b0));
    send_led(rand_led(1'b1));
  endtask

  // receiver holds off long enough that the block stalls its input
  task automatic test_backpressure();
    set_led_count(16'd8);
    hold_req = 1'b1;
    repeat (40) send_led(rand_led($urandom_range(0, 7) == 0));
  endtask

  // random phases of counts and mostly well-formed frames
  task automatic test_random();
    int unsigned sent;
    int unsigned n;
    int unsigned flen;
    int unsigned pos;
    logic [15:0] cnt;
    bit last;
    sent = 0;
    while (sent < RANDOM_LEDS) begin
      case ($urandom_range(0, 7))
        0: cnt = 16'd1;
        1: cnt = 16'($urandom_range(2, 20));
        2: cnt = 16'd490;
        3: cnt = 16'd491;
        4: cnt = 16'hffff;
        5: cnt = 16'($urandom_range(492, 65534));
        6: cnt = 16'($urandom_range(21, 489));
        default: cnt = 16'($urandom_range(1, 8));
      endcase
      set_led_count(cnt);
      n = $urandom_range(10, 40);
      flen = $urandom_range(1, 12);
      pos = 0;
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
        else last = (pos + 1 == flen);
        send_led(rand_led(last));
        pos = last ? 0 : pos + 1;
        sent++;
      end
    end
  endtask

  // receiver stall pattern, with an occasional long hold-off
  always @(posedge clk) begin
    stall_tick++;
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(10, 80);
    end else begin
      mode_left--;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ((stall_tick % 5) < 2);
      endcase
    end
  end

  // compare each accepted byte with the oldest expected one
  always @(posedge clk) begin
    lrup_pkg::byte_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h/%b/%b", $time,
                 out_word.payload_byte, out_word.packet_end, out_word.run_last);
        mismatches++;
      end else begin
        exp_w = pending_bytes.pop_front();
        if (out_word.payload_byte !== exp_w.payload_byte) begin
          $display("%0t: payload_byte expected %h actual %h", $time,
                   exp_w.payload_byte, out_word.payload_byte);
          mismatches++;
        end
        if (out_word.packet_end !== exp_w.packet_end) begin
          $display("%0t: packet_end expected %b actual %b", $time,
                   exp_w.packet_end, out_word.packet_end);
          mismatches++;
        end
        if (out_word.run_last !== exp_w.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time,
                   exp_w.run_last, out_word.run_last);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes outstanding", $time, pending_bytes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_count();
    test_single_frames();
    test_zero_count();
    test_chunk_headers();
    test_count_change();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
